// ----- hdl/hcbd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcbd_pkg: shared types and constants for the chunked body decoder
// Result status codes, framing characters and character classifiers.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  typedef enum logic [2:0] {
    ST_PAYLOAD = 3'd0,
    ST_END     = 3'd1,
    ST_CRLF    = 3'd2,
    ST_LINE    = 3'd3,
    ST_OVF     = 3'd4
  } status_t;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;

  // {is_hex, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

endpackage
`default_nettype wire

// ----- hdl/http_chunked_body_decoder_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_top: chunked transfer framing remover
//
// channel  direction  handshake            payload
// in       sink       in_valid / in_stall  body_byte[7:0]
// out      source     out_valid/out_stall  status[2:0], payload_byte[7:0]
//
// One body byte per clock while in_stall is low; each request is decoded in
// the cycle it is taken and its result (if any) is registered in the output
// register, or, while the output is stalled, in a skid register behind it
// that lets one more request in; in_stall is that register's full flag.
// rst is synchronous, active high, and returns the parser to the size line.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_top #(
  parameter int SIZE_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        body_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output hcbd_pkg::status_t      status,
  output logic [7:0]             payload_byte
);
  import hcbd_pkg::*;

  typedef enum logic [2:0] {
    PH_SIZE     = 3'd0,
    PH_DATA     = 3'd1,
    PH_CR       = 3'd2,
    PH_LF       = 3'd3,
    PH_END      = 3'd4,
    PH_ERR_CRLF = 3'd5,
    PH_ERR_LINE = 3'd6,
    PH_ERR_OVF  = 3'd7
  } phase_t;

  phase_t               phase, phase_next;
  logic [SIZE_BITS-1:0] chunk_left, chunk_left_next;
  logic                 digit_seen, digit_seen_next;
  logic                 parse_stopped, parse_stopped_next;

  logic                 skid_valid;
  status_t              skid_status;
  logic [7:0]           skid_byte;

  logic                 res_valid;
  status_t              res_status;
  logic [7:0]           res_byte;

  logic                 accept, take;
  logic [4:0]           hex;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign take     = out_valid && !out_stall;
  assign hex      = hex_digit(body_byte);

  always_comb begin
    phase_next         = phase;
    chunk_left_next    = chunk_left;
    digit_seen_next    = digit_seen;
    parse_stopped_next = parse_stopped;
    res_valid          = 1'b0;
    res_status         = ST_PAYLOAD;
    res_byte           = 8'd0;
    if (accept) begin
      case (phase)
        PH_SIZE: begin
          if (body_byte == CH_LF) begin
            if (!digit_seen) begin
              phase_next = PH_ERR_LINE;
              res_valid  = 1'b1;
              res_status = ST_LINE;
            end else begin
              digit_seen_next    = 1'b0;
              parse_stopped_next = 1'b0;
              if (chunk_left == '0) begin
                phase_next = PH_END;
                res_valid  = 1'b1;
                res_status = ST_END;
              end else begin
                phase_next = PH_DATA;
              end
            end
          end else if (!parse_stopped) begin
            if (!hex[4]) begin
              // leading blanks are skipped; anything else ends the size
              if (digit_seen || !is_blank(body_byte)) begin
                parse_stopped_next = 1'b1;
              end
            end else if (chunk_left[SIZE_BITS-1 -: 4] != 4'd0) begin
              phase_next = PH_ERR_OVF;
              res_valid  = 1'b1;
              res_status = ST_OVF;
            end else begin
              chunk_left_next = {chunk_left[SIZE_BITS-5:0], hex[3:0]};
              digit_seen_next = 1'b1;
            end
          end
        end
        PH_DATA: begin
          chunk_left_next = chunk_left - SIZE_BITS'(1);
          if (chunk_left == SIZE_BITS'(1)) begin
            phase_next = PH_CR;
          end
          res_valid  = 1'b1;
          res_status = ST_PAYLOAD;
          res_byte   = body_byte;
        end
        PH_CR: begin
          if (body_byte != CH_CR) begin
            phase_next = PH_ERR_CRLF;
            res_valid  = 1'b1;
            res_status = ST_CRLF;
          end else begin
            phase_next = PH_LF;
          end
        end
        PH_LF: begin
          if (body_byte != CH_LF) begin
            phase_next = PH_ERR_CRLF;
            res_valid  = 1'b1;
            res_status = ST_CRLF;
          end else begin
            phase_next         = PH_SIZE;
            chunk_left_next    = '0;
            digit_seen_next    = 1'b0;
            parse_stopped_next = 1'b0;
          end
        end
        PH_END: begin
        end
        PH_ERR_CRLF: begin
          res_valid  = 1'b1;
          res_status = ST_CRLF;
        end
        PH_ERR_LINE: begin
          res_valid  = 1'b1;
          res_status = ST_LINE;
        end
        default: begin
          res_valid  = 1'b1;
          res_status = ST_OVF;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SIZE;
      chunk_left    <= '0;
      digit_seen    <= 1'b0;
      parse_stopped <= 1'b0;
      out_valid     <= 1'b0;
      skid_valid    <= 1'b0;
    end else begin
      phase         <= phase_next;
      chunk_left    <= chunk_left_next;
      digit_seen    <= digit_seen_next;
      parse_stopped <= parse_stopped_next;
      if (!out_valid || take) begin
        if (skid_valid) begin
          // no request is taken while skid is full, so nothing new to place
          out_valid    <= 1'b1;
          status       <= skid_status;
          payload_byte <= skid_byte;
          skid_valid   <= 1'b0;
        end else begin
          out_valid    <= res_valid;
          status       <= res_status;
          payload_byte <= res_byte;
        end
      end else if (res_valid) begin
        skid_valid  <= 1'b1;
        skid_status <= res_status;
        skid_byte   <= res_byte;
      end
    end
  end

  // skid only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid full with output register empty");

  a_data_has_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (chunk_left != '0))
    else $error("data phase with zero bytes left");

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ERR_CRLF || phase == PH_ERR_LINE || phase == PH_ERR_OVF)
      |=> (phase == $past(phase)))
    else $error("error phase left");

  a_nonpayload_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_PAYLOAD) |-> (payload_byte == 8'd0))
    else $error("nonzero byte on a non-payload result");

endmodule
`default_nettype wire
